>>> src/png_scanline_unfilter_rgba_macros.svh
// ----------------------------------------------------------------------------
// PNG unfilter assertion macros
// Shared concurrent assertion forms for the unfilter block.
// ----------------------------------------------------------------------------
`ifndef PNG_SCANLINE_UNFILTER_RGBA_MACROS_SVH
`define PNG_SCANLINE_UNFILTER_RGBA_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define PNGU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition implies another in the next cycle.
`define PNGU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/pngu_pkg.sv
// ----------------------------------------------------------------------------
// PNG unfilter package
// Types, codes and default sizes shared by the unfilter files.
// ----------------------------------------------------------------------------
package pngu_pkg;

	// Default geometry limits
	localparam int MAX_WIDTH_DEF  = 8192;
	localparam int MAX_HEIGHT_DEF = 8192;

	// Configuration port
	localparam int CFG_DATA_W  = 14;
	localparam int CFG_INDEX_W = 2;
	typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
	typedef logic [CFG_DATA_W-1:0]  cfg_data_t;

	localparam cfg_index_t CFG_IMAGE_WIDTH  = 2'd0;
	localparam cfg_index_t CFG_IMAGE_HEIGHT = 2'd1;
	localparam cfg_index_t CFG_HAS_ALPHA    = 2'd2;

	localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
	localparam logic [7:0] FILTER_MAX   = 8'd4;

	// Row filter types
	typedef enum logic [2:0] {
		FILT_NONE  = 3'd0,
		FILT_SUB   = 3'd1,
		FILT_UP    = 3'd2,
		FILT_AVG   = 3'd3,
		FILT_PAETH = 3'd4
	} filter_t;

	// Input transaction payload
	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_of_image;
	} byte_item_t;

	// Output transaction payload
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       end_of_row;
		logic       end_of_image;
		logic       bad_filter;
	} pixel_item_t;

	// Control carried by an item in the reconstruct stage
	typedef struct packed {
		logic       err;
		logic [1:0] chan;
		filter_t    filt;
		logic [7:0] x;
		logic       first_row;
		logic       eor;
		logic       eoi;
		logic       emit;
		logic       alpha_recon;
	} s1_ctl_t;

endpackage

>>> src/pngu_stream_if.sv
// ----------------------------------------------------------------------------
// PNG unfilter stream interface
// Valid/ready channel with a typed payload.
// ----------------------------------------------------------------------------
interface pngu_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

>>> src/png_scanline_unfilter_rgba.sv
// ----------------------------------------------------------------------------
// PNG scanline unfilter, RGB/RGBA 8-bit
// Undoes None/Sub/Up/Average/Paeth row filters on a byte stream, emits pixels.
// ----------------------------------------------------------------------------
// An accepted sample byte is registered in the reconstruct stage, then its pixel in the
// output register. Throughput: one byte per cycle while the output takes pixels; the row
// store takes one read at accept and one write as the stage moves on, per sample byte.
// Reset clears config, valid flags, position counters and neighbor registers at once;
// the row store is not cleared and needs no clearing pass, since every entry is written
// in a row before the next row reads it.
module png_scanline_unfilter_rgba #(
	parameter int MAX_WIDTH  = pngu_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = pngu_pkg::MAX_HEIGHT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  pngu_pkg::cfg_index_t cfg_index,
	input  pngu_pkg::cfg_data_t  cfg_data,
	pngu_stream_if.sink          bytes,
	pngu_stream_if.source        pixels
);
	import pngu_pkg::*;

	`include "png_scanline_unfilter_rgba_macros.svh"

	localparam int DEPTH = MAX_WIDTH * 4;
	localparam int AW    = $clog2(DEPTH);
	localparam int SW    = $clog2(DEPTH + 1);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

	// Configuration registers
	logic [CFG_DATA_W-1:0] image_width_q;
	logic [CFG_DATA_W-1:0] image_height_q;
	logic                  has_alpha_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= CFG_DATA_W'(1);
			image_height_q <= CFG_DATA_W'(1);
			has_alpha_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
				CFG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				CFG_HAS_ALPHA:    has_alpha_q    <= cfg_data[0];
				default:          ;
			endcase
		end
	end

	// Clamp geometry and derive the row length in bytes
	logic [WW-1:0] width_cl;
	logic [HW-1:0] height_cl;
	logic [SW-1:0] stride;

	always_comb begin
		if (image_width_q == '0)
			width_cl = WW'(1);
		else if (32'(image_width_q) > 32'(MAX_WIDTH))
			width_cl = WW'(MAX_WIDTH);
		else
			width_cl = WW'(image_width_q);

		if (image_height_q == '0)
			height_cl = HW'(1);
		else if (32'(image_height_q) > 32'(MAX_HEIGHT))
			height_cl = HW'(MAX_HEIGHT);
		else
			height_cl = HW'(image_height_q);

		if (has_alpha_q)
			stride = SW'({width_cl, 2'b00});
		else
			stride = SW'({width_cl, 1'b0}) + SW'(width_cl);
	end

	// Position state of the accept stage
	logic          awaiting_q;
	logic          halted_q;
	logic          first_row_q;
	filter_t       row_filter_q;
	logic [AW-1:0] pos_q;
	logic [RW-1:0] row_q;
	logic [1:0]    mod3_q;

	// Reconstruct stage and output register
	logic          valid_s1;
	s1_ctl_t       ctl_s1;
	logic [AW-1:0] addr_s1;
	logic [7:0]    rd_s1;
	logic          s1_go;
	logic          out_valid_q;
	pixel_item_t   out_q;

	// Accept-stage decode
	logic          accept, sop;
	logic [7:0]    x;
	logic          awaiting_e, halted_e, first_e;
	logic [AW-1:0] pos_e;
	logic [RW-1:0] row_e;
	logic [1:0]    mod3_e, chan;
	logic          is_sample, is_err, is_filt;
	logic          eor, eoi, last_chan, load_s1;

	assign bytes.ready = !valid_s1 || s1_go;
	assign accept      = bytes.valid && bytes.ready;
	assign sop         = bytes.payload.start_of_image;
	assign x           = bytes.payload.data_byte;

	always_comb begin
		awaiting_e = sop || awaiting_q;
		halted_e   = !sop && halted_q;
		first_e    = sop || first_row_q;
		pos_e      = sop ? '0 : pos_q;
		row_e      = sop ? '0 : row_q;
		mod3_e     = sop ? 2'd0 : mod3_q;

		is_sample = !halted_e && !awaiting_e;
		is_err    = !halted_e && awaiting_e && (x > FILTER_MAX);
		is_filt   = !halted_e && awaiting_e && (x <= FILTER_MAX);

		chan      = has_alpha_q ? pos_e[1:0] : mod3_e;
		last_chan = has_alpha_q ? (chan == 2'd3) : (chan == 2'd2);
		eor       = (SW'(pos_e) + SW'(1)) >= stride;
		eoi       = eor && ((HW'(row_e) + HW'(1)) >= height_cl);
		load_s1   = accept && (is_sample || is_err);
	end

	// Advance position counters on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q   <= 1'b1;
			halted_q     <= 1'b0;
			first_row_q  <= 1'b1;
			row_filter_q <= FILT_NONE;
			pos_q        <= '0;
			row_q        <= '0;
			mod3_q       <= 2'd0;
		end else if (accept) begin
			awaiting_q  <= awaiting_e;
			halted_q    <= halted_e;
			first_row_q <= first_e;
			pos_q       <= pos_e;
			row_q       <= row_e;
			mod3_q      <= mod3_e;
			if (is_err) begin
				halted_q <= 1'b1;
			end else if (is_filt) begin
				row_filter_q <= filter_t'(x[2:0]);
				awaiting_q   <= 1'b0;
			end else if (is_sample) begin
				if (eor) begin
					pos_q       <= '0;
					mod3_q      <= 2'd0;
					awaiting_q  <= 1'b1;
					first_row_q <= 1'b0;
					row_q       <= row_e + RW'(1);
					if (eoi) begin
						row_q       <= '0;
						first_row_q <= 1'b1;
					end
				end else begin
					pos_q  <= pos_e + AW'(1);
					mod3_q <= (mod3_e == 2'd2) ? 2'd0 : mod3_e + 2'd1;
				end
			end
		end
	end

	// Hold an item in the reconstruct stage until the output can take it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (load_s1)
			valid_s1 <= 1'b1;
		else if (s1_go)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			ctl_s1.err         <= is_err;
			ctl_s1.chan        <= chan;
			ctl_s1.filt        <= row_filter_q;
			ctl_s1.x           <= x;
			ctl_s1.first_row   <= first_e;
			ctl_s1.eor         <= eor;
			ctl_s1.eoi         <= eoi;
			ctl_s1.emit        <= is_err || last_chan || eor;
			ctl_s1.alpha_recon <= has_alpha_q && (chan == 2'd3);
			addr_s1            <= pos_e;
		end
	end

	// Row store: read at accept, write back at reconstruct
	logic [7:0]    row_mem [DEPTH];
	logic          rd_en, wr_en;
	logic [7:0]    recon;

	assign rd_en = load_s1 && is_sample;
	assign wr_en = s1_go && !ctl_s1.err;

	always_ff @(posedge clk) begin
		if (wr_en)
			row_mem[addr_s1] <= recon;
		if (rd_en)
			rd_s1 <= row_mem[pos_e];
	end

	// Neighbor registers
	logic [7:0] left_q  [4];
	logic [7:0] ul_q    [4];
	logic [7:0] pixel_q [3];

	// Predict and reconstruct
	logic [7:0] a, b, c, pred, pa, pb;
	logic [9:0] sum_ab, cc, pc;

	always_comb begin
		a      = left_q[ctl_s1.chan];
		c      = ul_q[ctl_s1.chan];
		b      = ctl_s1.first_row ? 8'd0 : rd_s1;
		sum_ab = {2'b00, a} + {2'b00, b};
		cc     = {1'b0, c, 1'b0};
		pa     = (b >= c) ? b - c : c - b;
		pb     = (a >= c) ? a - c : c - a;
		pc     = (sum_ab >= cc) ? sum_ab - cc : cc - sum_ab;

		case (ctl_s1.filt)
			FILT_NONE: pred = 8'd0;
			FILT_SUB:  pred = a;
			FILT_UP:   pred = b;
			FILT_AVG:  pred = sum_ab[8:1];
			FILT_PAETH: begin
				if (pa <= pb && {2'b00, pa} <= pc)
					pred = a;
				else if ({2'b00, pb} <= pc)
					pred = b;
				else
					pred = c;
			end
			default:   pred = 8'd0;
		endcase
		recon = ctl_s1.x + pred;
	end

	assign s1_go = valid_s1 && (!ctl_s1.emit || !out_valid_q || pixels.ready);

	// Update neighbors; a row end or a start mark clears the left and upper-left registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				left_q[i] <= 8'd0;
				ul_q[i]   <= 8'd0;
			end
			for (int i = 0; i < 3; i++)
				pixel_q[i] <= 8'd0;
		end else begin
			if (wr_en) begin
				if (ctl_s1.eor) begin
					for (int i = 0; i < 4; i++) begin
						left_q[i] <= 8'd0;
						ul_q[i]   <= 8'd0;
					end
				end else begin
					left_q[ctl_s1.chan] <= recon;
					ul_q[ctl_s1.chan]   <= b;
				end
				if (ctl_s1.chan != 2'd3)
					pixel_q[ctl_s1.chan] <= recon;
			end
			if (accept && sop) begin
				for (int i = 0; i < 4; i++) begin
					left_q[i] <= 8'd0;
					ul_q[i]   <= 8'd0;
				end
			end
		end
	end

	// Assemble the result transaction
	pixel_item_t out_d;

	always_comb begin
		if (ctl_s1.err) begin
			out_d            = '0;
			out_d.bad_filter = 1'b1;
		end else begin
			out_d.red          = (ctl_s1.chan == 2'd0) ? recon : pixel_q[0];
			out_d.green        = (ctl_s1.chan == 2'd1) ? recon : pixel_q[1];
			out_d.blue         = (ctl_s1.chan == 2'd2) ? recon : pixel_q[2];
			out_d.alpha        = ctl_s1.alpha_recon ? recon : ALPHA_OPAQUE;
			out_d.end_of_row   = ctl_s1.eor;
			out_d.end_of_image = ctl_s1.eoi;
			out_d.bad_filter   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (s1_go && ctl_s1.emit)
			out_valid_q <= 1'b1;
		else if (pixels.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s1_go && ctl_s1.emit)
			out_q <= out_d;
	end

	assign pixels.valid   = out_valid_q;
	assign pixels.payload = out_q;

	// Checks
	`PNGU_ASSERT_IMP(a_store_no_collide, clk, arst_n, rd_en && wr_en, pos_e != addr_s1, "row store read and write hit the same entry")
	`PNGU_ASSERT_IMP(a_eoi_on_eor, clk, arst_n, out_valid_q && out_q.end_of_image, out_q.end_of_row, "end of image without end of row")
	`PNGU_ASSERT_IMP(a_err_clean, clk, arst_n, out_valid_q && out_q.bad_filter, !out_q.end_of_row && out_q.red == 8'd0 && out_q.alpha == 8'd0, "error transaction carries pixel data")
	`PNGU_ASSERT_NEXT(a_err_halts, clk, arst_n, load_s1 && is_err, halted_q || $past(sop) == 1'b0, "filter error did not halt")

endmodule

>>> sim/tb_png_scanline_unfilter_rgba.sv
// ----------------------------------------------------------------------------
// PNG scanline unfilter testbench
// Streams filter and sample bytes into the unfilter block through random
// valid/ready idling and compares each emitted pixel, field by field, with a
// local prediction of the None/Sub/Up/Average/Paeth reconstruction.
// Directed tests cover reset geometry, every row filter, bad filter bytes,
// start marks, geometry limits and mid-image register changes; random image
// streams with noise, plus a long output stall, fill the rest of the run.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_png_scanline_unfilter_rgba;
	import pngu_pkg::*;

	localparam int STORE_DEPTH  = MAX_WIDTH_DEF * 4;
	localparam int RANDOM_BYTES = 1100;
	localparam int GAP_MAX      = 12;
	localparam int LAT_SLACK    = 8;
	localparam int HOLD_CYCLES  = 300;
	localparam int MAX_PRINTS   = 20;
	localparam int WIDE_BYTES   = 16;
	localparam int TALL_ROWS    = 24;
	localparam cfg_index_t CFG_UNUSED_IDX = 2'd3;
	localparam cfg_data_t  GEOM_ALL_ONES  = 14'h3FFF;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	cfg_index_t cfg_index;
	cfg_data_t  cfg_data;

	pngu_stream_if #(.payload_t(byte_item_t))  bytes_if ();
	pngu_stream_if #(.payload_t(pixel_item_t)) pixels_if ();

	png_scanline_unfilter_rgba u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.bytes    (bytes_if),
		.pixels   (pixels_if)
	);

	// Idling knobs for the byte sender and the pixel sink
	int tx_gap_max  = 0;
	int rx_gap_max  = 0;
	int rx_hold_len = 0;

	// Run statistics
	int err_count    = 0;
	int bytes_sent   = 0;
	int pixels_seen  = 0;
	int rows_closed  = 0;
	int images_done  = 0;
	int bad_seen     = 0;
	int phases_run   = 0;
	int long_stalls  = 0;

	// Pixels predicted but not yet seen at the output
	pixel_item_t pending_pixels[$];

	// Unfilter state as the block should hold it
	bit [7:0]    row_above [0:STORE_DEPTH-1];
	bit [7:0]    left_px [4];
	bit [7:0]    upleft_px [4];
	bit [7:0]    pix_hold [3];
	filter_t     cur_filter;
	int unsigned byte_pos;
	int unsigned row_cnt;
	bit          want_filter;
	bit          first_row;
	bit          halted;
	int unsigned cfg_width;
	int unsigned cfg_height;
	bit          cfg_alpha;
	// Smallest row length used since the current image began
	int unsigned img_min_stride;

	// Clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog
	initial begin
		#4_000_000;
		$display("Timeout: %0d pixels still pending", pending_pixels.size());
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic int unsigned clamp_geom(int unsigned v, int unsigned hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic int unsigned cur_stride();
		return clamp_geom(cfg_width, MAX_WIDTH_DEF) * (cfg_alpha ? 4 : 3);
	endfunction

	function automatic logic [7:0] filt_byte(filter_t f);
		return {5'd0, f};
	endfunction

	function automatic void begin_row();
		for (int i = 0; i < 4; i++) begin
			left_px[i]   = '0;
			upleft_px[i] = '0;
		end
		byte_pos    = 0;
		want_filter = 1'b1;
	endfunction

	function automatic void begin_image();
		begin_row();
		row_cnt        = 0;
		first_row      = 1'b1;
		halted         = 1'b0;
		img_min_stride = cur_stride();
	endfunction

	function automatic void model_reset();
		cfg_width  = 1;
		cfg_height = 1;
		cfg_alpha  = 1'b0;
		for (int i = 0; i < 3; i++) pix_hold[i] = '0;
		cur_filter = FILT_NONE;
		begin_image();
	endfunction

	// Paeth predictor: pick the neighbor closest to a + b - c
	function automatic logic [7:0] paeth_pick(logic [7:0] a, logic [7:0] b, logic [7:0] c);
		int pa;
		int pb;
		int pc;
		pa = int'(b) - int'(c);
		pb = int'(a) - int'(c);
		pc = int'(a) + int'(b) - 2 * int'(c);
		if (pa < 0) pa = -pa;
		if (pb < 0) pb = -pb;
		if (pc < 0) pc = -pc;
		if (pa <= pb && pa <= pc) return a;
		if (pb <= pc) return b;
		return c;
	endfunction

	// Advance the predicted state by one byte; return 1 when a pixel results
	function automatic bit unfilter_byte(input logic [7:0] x, input logic sop,
			output pixel_item_t px);
		int unsigned bpp;
		int unsigned stride;
		int unsigned height;
		int unsigned pos;
		int unsigned k;
		logic [7:0]  a;
		logic [7:0]  b;
		logic [7:0]  c;
		logic [7:0]  pred;
		logic [7:0]  recon;
		bit          eor;
		bit          eoi;
		px     = '0;
		bpp    = cfg_alpha ? 4 : 3;
		stride = cur_stride();
		height = clamp_geom(cfg_height, MAX_HEIGHT_DEF);
		if (sop) begin_image();
		if (halted) return 1'b0;
		if (want_filter) begin
			if (x > FILTER_MAX) begin
				px.bad_filter = 1'b1;
				halted        = 1'b1;
				return 1'b1;
			end
			cur_filter  = filter_t'(x[2:0]);
			want_filter = 1'b0;
			return 1'b0;
		end
		pos = byte_pos % STORE_DEPTH;
		k   = byte_pos % bpp;
		a   = left_px[k];
		b   = first_row ? 8'd0 : row_above[pos];
		c   = upleft_px[k];
		case (cur_filter)
			FILT_SUB:   pred = a;
			FILT_UP:    pred = b;
			FILT_AVG:   pred = 8'((16'(a) + 16'(b)) >> 1);
			FILT_PAETH: pred = paeth_pick(a, b, c);
			default:    pred = 8'd0;
		endcase
		recon          = x + pred;
		row_above[pos] = recon;
		upleft_px[k]   = b;
		left_px[k]     = recon;
		if (k < 3) pix_hold[k] = recon;
		eor = (byte_pos + 1 >= stride);
		eoi = eor && (row_cnt + 1 >= height);
		if (eor) begin
			begin_row();
			first_row = 1'b0;
			row_cnt++;
			if (eoi) begin_image();
		end else begin
			byte_pos++;
		end
		if (k != bpp - 1 && !eor) return 1'b0;
		px.red          = pix_hold[0];
		px.green        = pix_hold[1];
		px.blue         = pix_hold[2];
		px.alpha        = (bpp == 4 && k == 3) ? recon : ALPHA_OPAQUE;
		px.end_of_row   = eor;
		px.end_of_image = eoi;
		return 1'b1;
	endfunction

	task automatic report_mismatch(string msg);
		if (err_count < MAX_PRINTS) $display("MISMATCH at %0t: %s", $realtime, msg);
		err_count++;
	endtask

	task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("pixel %0d %s got %0h want %0h",
				pixels_seen, name, got, want));
	endtask

	// Compare one output transaction with the oldest prediction
	task automatic check_pixel(pixel_item_t got);
		pixel_item_t want;
		if (pending_pixels.size() == 0) begin
			report_mismatch($sformatf("unexpected pixel %0h", got));
		end else begin
			want = pending_pixels.pop_front();
			check_field("red", got.red, want.red);
			check_field("green", got.green, want.green);
			check_field("blue", got.blue, want.blue);
			check_field("alpha", got.alpha, want.alpha);
			check_field("end_of_row", 8'(got.end_of_row), 8'(want.end_of_row));
			check_field("end_of_image", 8'(got.end_of_image), 8'(want.end_of_image));
			check_field("bad_filter", 8'(got.bad_filter), 8'(want.bad_filter));
		end
		pixels_seen++;
		if (got.end_of_row) rows_closed++;
		if (got.end_of_image) images_done++;
		if (got.bad_filter) bad_seen++;
	endtask

	always @(posedge clk) begin
		if (arst_n && pixels_if.valid && pixels_if.ready) check_pixel(pixels_if.payload);
	end

	// Pixel sink: random ready gaps, plus a long hold when one is requested
	initial begin : pixel_sink
		int gap;
		int hold;
		pixels_if.ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (rx_hold_len > 0) begin
				hold        = rx_hold_len;
				rx_hold_len = 0;
				long_stalls++;
				pixels_if.ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			gap = $urandom_range(0, rx_gap_max);
			if (gap > 0) begin
				pixels_if.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pixels_if.ready <= 1'b1;
			do @(posedge clk); while (!pixels_if.valid);
		end
	end

	// Offer one byte after a random gap and predict once it is accepted
	task automatic send_byte(logic [7:0] data, logic sop);
		int          gap;
		byte_item_t  item;
		pixel_item_t px;
		item.data_byte      = data;
		item.start_of_image = sop;
		gap = $urandom_range(0, tx_gap_max);
		if (gap > 0) begin
			bytes_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		bytes_if.valid   <= 1'b1;
		bytes_if.payload <= item;
		do @(posedge clk); while (!bytes_if.ready);
		if (unfilter_byte(data, sop, px)) pending_pixels.push_back(px);
		bytes_sent++;
	endtask

	// Drop valid and wait until every predicted pixel has come out
	task automatic wait_idle();
		bytes_if.valid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (LAT_SLACK) @(posedge clk);
	endtask

	task automatic write_reg(cfg_index_t idx, cfg_data_t val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_IMAGE_WIDTH:  cfg_width  = 32'(val);
			CFG_IMAGE_HEIGHT: cfg_height = 32'(val);
			CFG_HAS_ALPHA:    cfg_alpha  = val[0];
			default:          ;
		endcase
		if (cur_stride() < img_min_stride) img_min_stride = cur_stride();
	endtask

	task automatic set_geometry(cfg_data_t w, cfg_data_t h, bit alpha);
		write_reg(CFG_IMAGE_WIDTH, w);
		write_reg(CFG_IMAGE_HEIGHT, h);
		write_reg(CFG_HAS_ALPHA, {13'd0, alpha});
	endtask

	// Send one row: filter byte, then a full row of random samples
	task automatic send_random_row(logic [7:0] filt, logic sop);
		int unsigned n;
		n = cur_stride();
		send_byte(filt, sop);
		for (int unsigned i = 0; i < n; i++) send_byte(8'($urandom), 1'b0);
	endtask

	// Reset geometry is one RGB pixel; bytes after it restart the image
	task automatic test_reset_defaults();
		tx_gap_max = GAP_MAX;
		rx_gap_max = GAP_MAX;
		send_byte(filt_byte(FILT_NONE), 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(filt_byte(FILT_SUB), 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'hFE, 1'b0);
		wait_idle();
	endtask

	// One row per filter type over a two-pixel RGB image
	task automatic test_each_filter();
		set_geometry(14'd2, 14'd5, 1'b0);
		send_byte(filt_byte(FILT_NONE), 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'hFE, 1'b0);
		send_byte(8'h01, 1'b0);
		send_random_row(filt_byte(FILT_SUB), 1'b0);
		send_random_row(filt_byte(FILT_UP), 1'b0);
		send_random_row(filt_byte(FILT_AVG), 1'b0);
		send_random_row(filt_byte(FILT_PAETH), 1'b0);
		wait_idle();
	endtask

	// Bad filter bytes halt until a start mark; start marks cut a row short
	task automatic test_bad_filter_and_start();
		send_byte(FILTER_MAX + 8'd1, 1'b1);
		send_byte(filt_byte(FILT_NONE), 1'b0);
		send_byte(8'h33, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(filt_byte(FILT_SUB), 1'b0);
		send_byte(filt_byte(FILT_AVG), 1'b1);
		send_byte(8'hC3, 1'b0);
		send_byte(8'h3C, 1'b0);
		send_byte(8'h5A, 1'b0);
		send_byte(8'hA5, 1'b0);
		send_byte(filt_byte(FILT_PAETH), 1'b1);
		send_byte(8'h11, 1'b0);
		wait_idle();
	endtask

	// Register changes within an image that never grow the row length
	task automatic test_midimage_change();
		set_geometry(14'd4, 14'd3, 1'b1);
		send_random_row(filt_byte(FILT_SUB), 1'b1);
		send_byte(filt_byte(FILT_PAETH), 1'b0);
		for (int i = 0; i < 7; i++) send_byte(8'($urandom), 1'b0);
		wait_idle();
		// shrink to two RGB pixels; the partial row ends on the next byte
		set_geometry(14'd2, 14'd5, 1'b0);
		send_byte(8'($urandom), 1'b0);
		send_random_row(filt_byte(FILT_UP), 1'b0);
		send_random_row(filt_byte(FILT_AVG), 1'b0);
		wait_idle();
		// lower the height under the current row count
		write_reg(CFG_IMAGE_HEIGHT, 14'd1);
		send_random_row(filt_byte(FILT_PAETH), 1'b0);
		wait_idle();
	endtask

	// Zero geometry acts as 1x1; all-ones geometry clamps to the maximum
	task automatic test_geometry_limits();
		set_geometry(14'd0, 14'd0, 1'b0);
		send_random_row(filt_byte(FILT_PAETH), 1'b1);
		send_random_row(filt_byte(FILT_SUB), 1'b0);
		wait_idle();
		tx_gap_max = 0;
		rx_gap_max = 0;
		// open the widest RGBA row; no row end may show this early
		set_geometry(GEOM_ALL_ONES, GEOM_ALL_ONES, 1'b1);
		send_byte(8'($urandom_range(0, 4)), 1'b1);
		for (int i = 0; i < WIDE_BYTES; i++) send_byte(8'($urandom), 1'b0);
		wait_idle();
		// tall image of one RGB pixel per row; no image end may show
		set_geometry(14'd1, GEOM_ALL_ONES, 1'b0);
		for (int r = 0; r < TALL_ROWS; r++)
			send_random_row(8'($urandom_range(0, 4)), r == 0);
		wait_idle();
	endtask

	// Stall the pixel side for a long stretch while bytes keep coming
	task automatic test_output_stall();
		set_geometry(14'd4, 14'd4, 1'b1);
		tx_gap_max  = 0;
		rx_gap_max  = 0;
		rx_hold_len = HOLD_CYCLES;
		for (int img = 0; img < 3; img++)
			for (int r = 0; r < 4; r++)
				send_random_row(8'($urandom_range(0, 4)), r == 0);
		wait_idle();
	endtask

	function automatic int pick_gap_max();
		case ($urandom_range(0, 2))
			0:       return 0;
			1:       return 3;
			default: return GAP_MAX;
		endcase
	endfunction

	// Random phases: new geometry, then mostly well-formed images with noise
	task automatic test_random_streams();
		int          start_bytes;
		int unsigned pick;
		int unsigned new_w;
		int unsigned new_h;
		bit          new_alpha;
		bit          wr_w;
		bit          wr_h;
		bit          wr_a;
		bit          force_sop;
		bit          broken;
		logic [7:0]  filt;
		int unsigned rows;
		int unsigned stride;
		start_bytes = bytes_sent;
		while (bytes_sent - start_bytes < RANDOM_BYTES) begin
			phases_run++;
			tx_gap_max = pick_gap_max();
			rx_gap_max = pick_gap_max();
			pick      = $urandom_range(0, 99);
			new_w     = (pick < 8) ? 0 : (pick < 80) ? $urandom_range(1, 4) : $urandom_range(5, 12);
			new_h     = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
			new_alpha = 1'($urandom_range(0, 1));
			wr_w      = $urandom_range(0, 3) != 0;
			wr_h      = $urandom_range(0, 3) != 0;
			wr_a      = $urandom_range(0, 3) != 0;
			if (!wr_w) new_w = cfg_width;
			if (!wr_a) new_alpha = cfg_alpha;
			// a longer row than the image has used so far needs a fresh image
			force_sop = clamp_geom(new_w, MAX_WIDTH_DEF) * (new_alpha ? 4 : 3) > img_min_stride;
			if (wr_w) write_reg(CFG_IMAGE_WIDTH, cfg_data_t'(new_w));
			if (wr_h) write_reg(CFG_IMAGE_HEIGHT, cfg_data_t'(new_h));
			if (wr_a) write_reg(CFG_HAS_ALPHA, {13'($urandom), new_alpha});
			if ($urandom_range(0, 9) == 0) write_reg(CFG_UNUSED_IDX, cfg_data_t'($urandom));
			if ($urandom_range(0, 5) == 0) begin
				// noise: random bytes with occasional start marks
				send_byte(8'($urandom), force_sop || $urandom_range(0, 7) == 0);
				for (int i = $urandom_range(10, 40); i > 0; i--)
					send_byte(8'($urandom), $urandom_range(0, 7) == 0);
			end else begin
				stride = cur_stride();
				rows   = clamp_geom(cfg_height, MAX_HEIGHT_DEF);
				for (int img = $urandom_range(1, 3); img > 0; img--) begin
					broken = 1'b0;
					for (int unsigned r = 0; r < rows && !broken; r++) begin
						filt = ($urandom_range(0, 24) == 0) ? 8'($urandom_range(5, 255))
							: 8'($urandom_range(0, 4));
						send_byte(filt, (r == 0) ? (force_sop || $urandom_range(0, 3) != 0)
							: ($urandom_range(0, 49) == 0));
						force_sop = 1'b0;
						if (filt > FILTER_MAX) begin
							for (int i = $urandom_range(1, 3); i > 0; i--)
								send_byte(8'($urandom), 1'b0);
							broken = 1'b1;
						end
						for (int unsigned i = 0; i < stride && !broken; i++) begin
							if ($urandom_range(0, 149) == 0) broken = 1'b1;
							else send_byte(8'($urandom), 1'b0);
						end
					end
					if (broken) force_sop = 1'b1;
				end
			end
			wait_idle();
		end
	endtask

	task automatic finish_run();
		wait_idle();
		$display("Covered %0d bytes (%0d random phases, %0d long output stalls)",
			bytes_sent, phases_run, long_stalls);
		$display("Checked %0d pixels: %0d rows, %0d images, %0d bad-filter results, %0d mismatches",
			pixels_seen, rows_closed, images_done, bad_seen, err_count);
		if (err_count == 0 && pending_pixels.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	endtask

	initial begin : run_tests
		arst_n           <= 1'b0;
		cfg_we           <= 1'b0;
		cfg_index        <= CFG_IMAGE_WIDTH;
		cfg_data         <= '0;
		bytes_if.valid   <= 1'b0;
		bytes_if.payload <= '0;
		model_reset();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_each_filter();
		test_bad_filter_and_start();
		test_midimage_change();
		test_geometry_limits();
		test_output_stall();
		test_random_streams();
		finish_run();
	end

endmodule
